// File: hw/rtl/abps_pkg.sv
// Package with the word types and codes of the alert beep pattern sequencer.
`default_nettype none
package abps_pkg;

	localparam logic OP_UPDATE  = 1'b0;
	localparam logic OP_SILENCE = 1'b1;

	localparam logic [2:0] ALERT_NONE = 3'd0;

	typedef struct packed {
		logic        op;
		logic [31:0] now_ms;
		logic [2:0]  alert;
		logic [7:0]  beep_count;
		logic [15:0] on_time_ms;
		logic [15:0] off_time_ms;
		logic [31:0] repeat_ms;
	} in_word_t;

	typedef struct packed {
		logic tone_on;
	} out_word_t;

endpackage
`default_nettype wire

// File: hw/rtl/abps_if.sv
// Valid/ready channel interfaces for the input and result words of the sequencer.
`default_nettype none
interface abps_in_if;
	import abps_pkg::*;

	logic     valid;
	logic     ready;
	in_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface abps_out_if;
	import abps_pkg::*;

	logic      valid;
	logic      ready;
	out_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/alert_beep_pattern_sequencer.sv
// Top level of the alert beep pattern sequencer: input register, state update and result register.
// The block takes words on the item channel and returns one word on the result
// channel for each of them, in order. An item word is either a timed update
// (op = OP_UPDATE) with a millisecond timestamp, an alert code and that alert's
// beep pattern, or a silence request (op = OP_SILENCE). The result word carries
// the buzzer level after that item.
// A word is taken into an input register; when the result register can advance,
// the sequencer state is updated and the tone level is written to the result
// register. One item per cycle is sustained while the receiver keeps ready
// high; the state update from one word to the next is combinational, with
// two 32-bit subtract-and-compare paths.
// Reset clears all sequencer state: no alert is active and the tone is off.
// When the receiver holds ready low, the result register keeps its word and
// the input register still accepts one more item if it is empty; after that
// item ready stays low until the result is taken.
`default_nettype none
module alert_beep_pattern_sequencer (
	input  wire         clk,
	input  wire         arst_n,
	abps_in_if.sink     item,
	abps_out_if.source  result
);
	import abps_pkg::*;

	logic        v_s1;
	in_word_t    data_s1;
	logic        adv;

	logic        out_valid_q;
	out_word_t   out_data_q;

	logic [2:0]  active_alert_q;
	logic [7:0]  beeps_left_q;
	logic        tone_active_q;
	logic [31:0] pattern_start_q;
	logic [31:0] phase_start_q;
	logic [7:0]  held_beep_count_q;
	logic [15:0] held_on_time_q;
	logic [15:0] held_off_time_q;
	logic [31:0] held_repeat_q;

	logic [2:0]  n_alert;
	logic [7:0]  n_beeps;
	logic        n_tone;
	logic [31:0] n_pattern_start;
	logic [31:0] n_phase_start;
	logic [7:0]  n_beep_count;
	logic [15:0] n_on_time;
	logic [15:0] n_off_time;
	logic [31:0] n_repeat;

	assign adv        = !out_valid_q || result.ready;
	assign item.ready = !v_s1 || adv;

	assign result.valid = out_valid_q;
	assign result.data  = out_data_q;

	always_comb begin
		logic [31:0] rep_elapsed;
		logic [31:0] phase_elapsed;
		rep_elapsed     = 32'd0;
		phase_elapsed   = 32'd0;
		n_alert         = active_alert_q;
		n_beeps         = beeps_left_q;
		n_tone          = tone_active_q;
		n_pattern_start = pattern_start_q;
		n_phase_start   = phase_start_q;
		n_beep_count    = held_beep_count_q;
		n_on_time       = held_on_time_q;
		n_off_time      = held_off_time_q;
		n_repeat        = held_repeat_q;
		if (data_s1.op == OP_SILENCE) begin
			n_tone  = 1'b0;
			n_beeps = 8'd0;
			n_alert = ALERT_NONE;
		end else begin
			if (data_s1.alert != active_alert_q) begin
				n_alert         = data_s1.alert;
				n_beep_count    = data_s1.beep_count;
				n_on_time       = data_s1.on_time_ms;
				n_off_time      = data_s1.off_time_ms;
				n_repeat        = data_s1.repeat_ms;
				n_beeps         = data_s1.beep_count;
				n_pattern_start = data_s1.now_ms;
				n_phase_start   = data_s1.now_ms;
				n_tone          = 1'b0;
			end
			rep_elapsed   = data_s1.now_ms - n_pattern_start;
			phase_elapsed = data_s1.now_ms - n_phase_start;
			if (data_s1.alert != ALERT_NONE) begin
				if (n_beeps == 8'd0) begin
					// The pattern is over; restart it once a nonzero repeat interval has passed.
					if (n_repeat != 32'd0 && rep_elapsed >= n_repeat) begin
						n_beeps         = n_beep_count;
						n_pattern_start = data_s1.now_ms;
						n_phase_start   = data_s1.now_ms;
					end
				end else if (n_tone) begin
					if (phase_elapsed >= {16'd0, n_on_time}) begin
						n_tone        = 1'b0;
						n_phase_start = data_s1.now_ms;
						n_beeps       = n_beeps - 8'd1;
					end
				end else if (phase_elapsed >= {16'd0, n_off_time}) begin
					n_tone        = 1'b1;
					n_phase_start = data_s1.now_ms;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (item.ready) begin
			v_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			data_s1 <= item.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			out_data_q.tone_on <= n_tone;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_alert_q    <= ALERT_NONE;
			beeps_left_q      <= 8'd0;
			tone_active_q     <= 1'b0;
			pattern_start_q   <= 32'd0;
			phase_start_q     <= 32'd0;
			held_beep_count_q <= 8'd0;
			held_on_time_q    <= 16'd0;
			held_off_time_q   <= 16'd0;
			held_repeat_q     <= 32'd0;
		end else if (adv && v_s1) begin
			active_alert_q    <= n_alert;
			beeps_left_q      <= n_beeps;
			tone_active_q     <= n_tone;
			pattern_start_q   <= n_pattern_start;
			phase_start_q     <= n_phase_start;
			held_beep_count_q <= n_beep_count;
			held_on_time_q    <= n_on_time;
			held_off_time_q   <= n_off_time;
			held_repeat_q     <= n_repeat;
		end
	end

endmodule
`default_nettype wire
